### sv/bkv_pkg.sv
// ----------------------------------------------------------------------------
// bkv_pkg
// Shared types and constants of the bounded key-value store.
// ----------------------------------------------------------------------------
package bkv_pkg;

	localparam int ENTRIES_DEF    = 16;
	localparam int KEY_BITS_DEF   = 32;
	localparam int VALUE_BITS_DEF = 32;
	localparam int QUEUE_DEPTH    = 2;

	localparam logic [1:0] KIND_PUT    = 2'd0;
	localparam logic [1:0] KIND_GET    = 2'd1;
	localparam logic [1:0] KIND_REMOVE = 2'd2;
	localparam logic [1:0] KIND_NONE   = 2'd3;

	localparam logic       REG_POLICY   = 1'b0;
	localparam logic       REG_CAPACITY = 1'b1;
	localparam logic [4:0] CAPACITY_RESET = 5'd16;

	// Result of one operation as it leaves the back end.
	typedef struct packed {
		logic        hit;
		logic [31:0] read_value;
		logic        done_ok;
		logic        evicted;
		logic [31:0] evicted_key;
	} result_t;

endpackage

### sv/bkv_front.sv
// ----------------------------------------------------------------------------
// bkv_front
// Accepts items, masks key and value and stores them with the kind in a short queue.
// ----------------------------------------------------------------------------
module bkv_front #(
	parameter int KEY_BITS   = bkv_pkg::KEY_BITS_DEF,
	parameter int VALUE_BITS = bkv_pkg::VALUE_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	output logic                  full,
	input  logic [1:0]            kind,
	input  logic [31:0]           key,
	input  logic [31:0]           value,
	output logic                  req_valid,
	input  logic                  req_take,
	output logic [1:0]            req_kind,
	output logic [KEY_BITS-1:0]   req_key,
	output logic [VALUE_BITS-1:0] req_value
);
	localparam int QD = bkv_pkg::QUEUE_DEPTH;

	logic [1:0]            kind_q  [QD];
	logic [KEY_BITS-1:0]   key_q   [QD];
	logic [VALUE_BITS-1:0] value_q [QD];
	logic                  wr_q, rd_q;
	logic [1:0]            count_q;
	logic                  do_push, do_pop;
	logic [63:0]           key_ext, value_ext;

	assign key_ext   = {32'd0, key};
	assign value_ext = {32'd0, value};
	assign full      = (count_q == 2'(QD));
	assign do_push   = push && !full;
	assign do_pop    = req_take && req_valid;
	assign req_valid = (count_q != 2'd0);
	assign req_kind  = kind_q[rd_q];
	assign req_key   = key_q[rd_q];
	assign req_value = value_q[rd_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			kind_q[wr_q]  <= kind;
			key_q[wr_q]   <= key_ext[KEY_BITS-1:0];
			value_q[wr_q] <= value_ext[VALUE_BITS-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= 1'b0;
			rd_q    <= 1'b0;
			count_q <= 2'd0;
		end else begin
			if (do_push) wr_q <= !wr_q;
			if (do_pop) rd_q <= !rd_q;
			count_q <= count_q + 2'(do_push) - 2'(do_pop);
		end
	end

`ifndef ASSERT_OFF
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= 2'(QD)) else $error("front queue overflow");
	a_count_track: assert property (@(posedge clk) disable iff (!arst_n)
		(do_push && !do_pop) |=> count_q == $past(count_q) + 2'd1)
		else $error("front count mismatch");
	a_pop_track: assert property (@(posedge clk) disable iff (!arst_n)
		(do_pop && !do_push) |=> count_q == $past(count_q) - 2'd1)
		else $error("front pop mismatch");
`endif

endmodule

### sv/bkv_back.sv
// ----------------------------------------------------------------------------
// bkv_back
// Carries out operations on the associative table and holds one result.
// ----------------------------------------------------------------------------
module bkv_back #(
	parameter int ENTRIES    = bkv_pkg::ENTRIES_DEF,
	parameter int KEY_BITS   = bkv_pkg::KEY_BITS_DEF,
	parameter int VALUE_BITS = bkv_pkg::VALUE_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  policy,
	input  logic [4:0]            capacity,
	input  logic                  req_valid,
	output logic                  req_take,
	input  logic [1:0]            req_kind,
	input  logic [KEY_BITS-1:0]   req_key,
	input  logic [VALUE_BITS-1:0] req_value,
	output logic                  res_valid,
	input  logic                  res_take,
	output bkv_pkg::result_t      res
);
	localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int CW = $clog2(ENTRIES + 1);

	typedef enum logic [2:0] {
		ST_IDLE   = 3'b001,
		ST_SEARCH = 3'b010,
		ST_APPLY  = 3'b100
	} state_t;

	state_t                st_q;
	logic [KEY_BITS-1:0]   keys_q   [ENTRIES];
	logic [VALUE_BITS-1:0] vals_q   [ENTRIES];
	logic [IW-1:0]         rank_q   [ENTRIES];
	logic [ENTRIES-1:0]    valid_q;
	logic [CW-1:0]         live_q;
	logic                  valid_res_q;

	// Search results, registered.
	logic [ENTRIES-1:0] match_q;
	logic               hit_q, old_any_q, free_any_q;
	logic [IW-1:0]      hidx_q, oidx_q, fidx_q;
	logic [IW-1:0]      hrank_q, orank_q;

	logic [ENTRIES-1:0] match_c, oldest_c;
	logic [IW-1:0]      hidx_c, oidx_c, fidx_c;
	logic               free_any_c;
	logic [CW-1:0]      cap_eff;

	always_comb begin
		match_c = '0;
		oldest_c = '0;
		hidx_c = '0;
		oidx_c = '0;
		fidx_c = '0;
		free_any_c = 1'b0;
		for (int i = ENTRIES - 1; i >= 0; i--) begin
			match_c[i]  = valid_q[i] && (keys_q[i] == req_key);
			oldest_c[i] = valid_q[i] && (rank_q[i] == '0);
			if (match_c[i]) hidx_c = IW'(i);
			if (oldest_c[i]) oidx_c = IW'(i);
			if (!valid_q[i]) begin
				fidx_c = IW'(i);
				free_any_c = 1'b1;
			end
		end
	end

	always_comb begin
		if (capacity == 5'd0) cap_eff = CW'(1);
		else if ({27'd0, capacity} > 32'(ENTRIES)) cap_eff = CW'(ENTRIES);
		else cap_eff = CW'(capacity);
	end

	logic is_put, need_evict, free_after, do_insert, do_newest, do_drop;
	logic [IW-1:0] ins_idx;
	logic [CW-1:0] live_mid;

	assign is_put     = (req_kind == bkv_pkg::KIND_PUT);
	assign need_evict = is_put && !hit_q && (live_q >= cap_eff) && old_any_q;
	// After an eviction the evicted slot is the lowest free one if below others.
	assign free_after = free_any_q || need_evict;
	assign ins_idx    = (need_evict && (!free_any_q || oidx_q < fidx_q)) ? oidx_q : fidx_q;
	assign do_insert  = is_put && !hit_q && free_after;
	assign do_newest  = policy && hit_q && (is_put || req_kind == bkv_pkg::KIND_GET);
	assign do_drop    = (req_kind == bkv_pkg::KIND_REMOVE) && hit_q;
	assign live_mid   = need_evict ? live_q - CW'(1) : live_q;

	assign req_take  = (st_q == ST_APPLY);
	assign res_valid = valid_res_q;

	always_ff @(posedge clk) begin
		if (st_q == ST_SEARCH) begin
			match_q    <= match_c;
			hit_q      <= |match_c;
			old_any_q  <= |oldest_c;
			free_any_q <= free_any_c;
			hidx_q     <= hidx_c;
			oidx_q     <= oidx_c;
			fidx_q     <= fidx_c;
			hrank_q    <= rank_q[hidx_c];
			orank_q    <= rank_q[oidx_c];
		end
		if (st_q == ST_APPLY) begin
			for (int j = 0; j < ENTRIES; j++) begin
				if (valid_q[j] && do_newest && IW'(j) != hidx_q && rank_q[j] > hrank_q)
					rank_q[j] <= rank_q[j] - IW'(1);
				if (valid_q[j] && do_drop && IW'(j) != hidx_q && rank_q[j] > hrank_q)
					rank_q[j] <= rank_q[j] - IW'(1);
				if (valid_q[j] && need_evict && IW'(j) != oidx_q && rank_q[j] > orank_q)
					rank_q[j] <= rank_q[j] - IW'(1);
			end
			if (do_newest) rank_q[hidx_q] <= IW'(live_q - CW'(1));
			if (is_put && hit_q) vals_q[hidx_q] <= req_value;
			if (do_insert) begin
				keys_q[ins_idx] <= req_key;
				vals_q[ins_idx] <= req_value;
				rank_q[ins_idx] <= IW'(live_mid);
			end
			res.hit         <= hit_q && (req_kind != bkv_pkg::KIND_NONE);
			res.done_ok     <= (is_put && (hit_q || do_insert)) || do_drop;
			res.evicted     <= need_evict;
			res.read_value  <= (req_kind == bkv_pkg::KIND_GET && hit_q) ?
				32'({{(64-VALUE_BITS){1'b0}}, vals_q[hidx_q]}) : 32'd0;
			res.evicted_key <= need_evict ?
				32'({{(64-KEY_BITS){1'b0}}, keys_q[oidx_q]}) : 32'd0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= ST_IDLE;
			valid_q     <= '0;
			live_q      <= '0;
			valid_res_q <= 1'b0;
		end else begin
			if (res_take && valid_res_q) valid_res_q <= 1'b0;
			case (st_q)
				ST_IDLE: begin
					if (req_valid && (!valid_res_q || res_take)) st_q <= ST_SEARCH;
				end
				ST_SEARCH: st_q <= ST_APPLY;
				ST_APPLY: begin
					st_q <= ST_IDLE;
					valid_res_q <= 1'b1;
					// The evicted slot may be refilled by the same put.
					if (need_evict && !(do_insert && ins_idx == oidx_q))
						valid_q[oidx_q] <= 1'b0;
					if (do_drop) valid_q[hidx_q] <= 1'b0;
					if (do_insert) valid_q[ins_idx] <= 1'b1;
					live_q <= live_mid + CW'(do_insert) - CW'(do_drop);
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end

`ifndef ASSERT_OFF
	a_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot(st_q)) else $error("state not one-hot");
	a_live_bound: assert property (@(posedge clk) disable iff (!arst_n)
		live_q <= CW'(ENTRIES)) else $error("live count out of range");
	a_live_match: assert property (@(posedge clk) disable iff (!arst_n)
		32'($countones(valid_q)) == 32'(live_q)) else $error("live count drift");
	a_hit_unique: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == ST_APPLY) |-> $onehot0(match_q)) else $error("duplicate key");
	a_no_res_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == ST_APPLY) |-> !valid_res_q)
		else $error("result overrun");
`endif

endmodule

### sv/bounded_kv_store_lru_fifo.sv
// ----------------------------------------------------------------------------
// bounded_kv_store_lru_fifo
// Fully associative key-value store with FIFO or LRU replacement.
// ----------------------------------------------------------------------------
//  channel   | handshake        | payload
//  ----------+------------------+-------------------------------------------
//  request   | push / full      | kind, key, value
//  result    | pop / empty      | hit, read_value, done_ok, evicted,
//            |                  | evicted_key
//  config    | cfg_we           | cfg_index, cfg_data
//
// An item passes through the back-end steps of dispatch, associative search and
// apply in the single search-and-update engine, which takes no new item until
// the last is applied. A two-entry queue in front takes items while the back
// end works. The result register holds one item; the back end waits on it while
// it is still unread. Reset clears the valid bits, the live count and both queues; no sweep.
module bounded_kv_store_lru_fifo #(
	parameter int ENTRIES    = bkv_pkg::ENTRIES_DEF,
	parameter int KEY_BITS   = bkv_pkg::KEY_BITS_DEF,
	parameter int VALUE_BITS = bkv_pkg::VALUE_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic [1:0]  kind,
	input  logic [31:0] key,
	input  logic [31:0] value,
	output logic        empty,
	input  logic        pop,
	output logic        hit,
	output logic [31:0] read_value,
	output logic        done_ok,
	output logic        evicted,
	output logic [31:0] evicted_key,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [4:0]  cfg_data
);
	// Configuration registers; the user must write them only while the store is idle, as the block does not enforce it.
	logic       policy_q;
	logic [4:0] capacity_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			policy_q   <= 1'b0;
			capacity_q <= bkv_pkg::CAPACITY_RESET;
		end else if (cfg_we) begin
			if (cfg_index == bkv_pkg::REG_POLICY) policy_q <= cfg_data[0];
			else capacity_q <= cfg_data;
		end
	end

	logic                  req_valid, req_take, res_valid;
	logic [1:0]            req_kind;
	logic [KEY_BITS-1:0]   req_key;
	logic [VALUE_BITS-1:0] req_value;
	bkv_pkg::result_t      res;

	// The front end masks and queues items.
	bkv_front #(.KEY_BITS(KEY_BITS), .VALUE_BITS(VALUE_BITS)) u_front (
		.clk, .arst_n, .push, .full, .kind, .key, .value,
		.req_valid, .req_take, .req_kind, .req_key, .req_value
	);

	// The back end searches and updates the table.
	bkv_back #(.ENTRIES(ENTRIES), .KEY_BITS(KEY_BITS), .VALUE_BITS(VALUE_BITS)) u_back (
		.clk, .arst_n, .policy(policy_q), .capacity(capacity_q),
		.req_valid, .req_take, .req_kind, .req_key, .req_value,
		.res_valid, .res_take(pop), .res
	);

	assign empty       = !res_valid;
	assign hit         = res.hit;
	assign read_value  = res.read_value;
	assign done_ok     = res.done_ok;
	assign evicted     = res.evicted;
	assign evicted_key = res.evicted_key;

endmodule
